// ===== hw/rtl/chained_int_key_value_table_unit_macros.svh =====
// Assertion macros shared by the key/value table RTL.
// No dependencies; included by modules that carry assertions.
`ifndef CHAINED_INT_KEY_VALUE_TABLE_UNIT_MACROS_SVH
`define CHAINED_INT_KEY_VALUE_TABLE_UNIT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define CKV_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);
// Next-cycle implication checked on every rising edge outside reset.
`define CKV_ASSERT_NXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);
`endif

// ===== hw/rtl/ckvt_pkg.sv =====
// Package for the chained key/value table: types, sizes and codes.
// No dependencies; used by every module of the block.
`default_nettype none
package ckvt_pkg;
  localparam int MaxBuckets = 64;
  localparam int ChainDepth = 4;
  localparam int SlotTotal  = MaxBuckets * ChainDepth;
  localparam int BucketW    = $clog2(MaxBuckets);
  localparam int SlotW      = $clog2(SlotTotal);
  localparam int ChainW     = (ChainDepth > 1) ? $clog2(ChainDepth) : 1;
  localparam int ChainCntW  = $clog2(ChainDepth + 1);
  localparam int KeyW       = 31;
  localparam int ValW       = 32;
  localparam int CountW     = 7;
  localparam int ModCntW    = $clog2(KeyW + 1);

  typedef enum logic [1:0] {
    FUNC_PUT = 2'd0, FUNC_GET = 2'd1, FUNC_REMOVE = 2'd2, FUNC_NOP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_MISS = 2'd1, ST_FULL = 2'd2, ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]      func;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ValW-1:0] read_value;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    func_t              func;
    logic [KeyW-1:0]    key;
    logic [ValW-1:0]    value;
    logic [BucketW-1:0] bucket;
  } cmd_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ckvt_front.sv =====
// Front end of the key/value table: accepts beats and computes the bucket
// by a restoring bit-serial modulo. Depends on ckvt_pkg.
`default_nettype none
module ckvt_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  output logic                                   full,
  input  wire ckvt_pkg::in_item_t                in_item,
  input  wire logic [ckvt_pkg::CountW-1:0]       count,
  output logic                                   cmd_valid,
  input  wire logic                              cmd_ready,
  output ckvt_pkg::cmd_t                         cmd
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_DIV = 3'b010, S_SEND = 3'b100
  } fstate_t;

  fstate_t                              state_r, state_nxt;
  ckvt_pkg::in_item_t                   item_r;
  logic [ckvt_pkg::CountW-1:0]          div_r;
  logic [ckvt_pkg::CountW-1:0]          rem_r;
  logic [ckvt_pkg::ModCntW-1:0]         bit_r;
  logic [ckvt_pkg::CountW:0]            trial;

  // Shift in the next key bit; remainder stays below the divisor.
  assign trial = {rem_r, item_r.key[bit_r[4:0]]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (push) state_nxt = S_DIV;
      S_DIV:  if (bit_r == '0) state_nxt = S_SEND;
      S_SEND: if (cmd_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (state_r == S_IDLE && push) begin
      item_r <= in_item;
      rem_r  <= '0;
      bit_r  <= ckvt_pkg::ModCntW'(ckvt_pkg::KeyW - 1);
      if (count == '0 || count > ckvt_pkg::CountW'(ckvt_pkg::MaxBuckets)) begin
        div_r <= ckvt_pkg::CountW'(ckvt_pkg::MaxBuckets);
      end else begin
        div_r <= count;
      end
    end else if (state_r == S_DIV) begin
      if (trial >= {1'b0, div_r}) begin
        rem_r <= ckvt_pkg::CountW'(trial - {1'b0, div_r});
      end else begin
        rem_r <= trial[ckvt_pkg::CountW-1:0];
      end
      bit_r <= bit_r - 1'b1;
    end
  end

  assign full       = (state_r != S_IDLE);
  assign cmd_valid  = (state_r == S_SEND);
  assign cmd.func   = ckvt_pkg::func_t'(item_r.func);
  assign cmd.key    = item_r.key;
  assign cmd.value  = item_r.value;
  assign cmd.bucket = rem_r[ckvt_pkg::BucketW-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/ckvt_queue.sv =====
// Two-entry command queue between front and back of the key/value table.
// Depends on ckvt_pkg and the shared assertion macros.
`default_nettype none
`include "chained_int_key_value_table_unit_macros.svh"
module ckvt_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire ckvt_pkg::cmd_t wr_cmd,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output ckvt_pkg::cmd_t      rd_cmd
);
  ckvt_pkg::cmd_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
    if (do_wr) mem_r[wp_r] <= wr_cmd;
  end

  `CKV_ASSERT_IMP(a_q_cnt, clk, rst_n, 1'b1, cnt_r != 2'd3, "queue count out of range")
  `CKV_ASSERT_NXT(a_q_grow, clk, rst_n, do_wr && !do_rd, cnt_r == $past(cnt_r) + 2'd1,
    "queue count did not grow on write")
  `CKV_ASSERT_IMP(a_q_ptr, clk, rst_n, cnt_r == 2'd0 || cnt_r == 2'd2, wp_r == rp_r,
    "queue pointers disagree with count")
endmodule
`default_nettype wire

// ===== hw/rtl/ckvt_back.sv =====
// Back end of the key/value table: walks one bucket's chain in the slot
// memories, updates them and emits one result. Depends on ckvt_pkg.
`default_nettype none
`include "chained_int_key_value_table_unit_macros.svh"
module ckvt_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire ckvt_pkg::cmd_t     cmd,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output ckvt_pkg::out_item_t     res
);
  typedef enum logic [4:0] {
    B_IDLE = 5'b00001, B_READ = 5'b00010, B_CHECK = 5'b00100,
    B_WRITE = 5'b01000, B_OUT = 5'b10000
  } bstate_t;

  bstate_t                        state_r, state_nxt;
  ckvt_pkg::cmd_t                 cmd_r;
  logic [ckvt_pkg::KeyW-1:0]      key_mem [ckvt_pkg::SlotTotal];
  logic [ckvt_pkg::ValW-1:0]      val_mem [ckvt_pkg::SlotTotal];
  logic [ckvt_pkg::SlotTotal-1:0] valid_r;
  logic [ckvt_pkg::KeyW-1:0]      key_rd_r;
  logic [ckvt_pkg::ValW-1:0]      val_rd_r;
  logic [ckvt_pkg::ChainCntW-1:0] idx_r;
  logic                           free_seen_r;
  logic [ckvt_pkg::ChainW-1:0]    free_idx_r;
  logic [ckvt_pkg::ChainW-1:0]    hit_idx_r;
  logic                           hit_r;
  logic [ckvt_pkg::SlotW-1:0]     rd_addr, wr_addr;
  logic                           cur_valid, cur_hit, last;
  logic [ckvt_pkg::ChainW-1:0]    idx_lo;
  logic                           wr_val_en, wr_key_en;
  ckvt_pkg::out_item_t            res_r;

  assign idx_lo    = idx_r[ckvt_pkg::ChainW-1:0];
  assign rd_addr   = ckvt_pkg::SlotW'(cmd_r.bucket * ckvt_pkg::ChainDepth) +
                     ckvt_pkg::SlotW'(idx_lo);
  assign cur_valid = valid_r[rd_addr];
  assign cur_hit   = cur_valid && (key_rd_r == cmd_r.key);
  assign last      = (idx_r == ckvt_pkg::ChainCntW'(ckvt_pkg::ChainDepth - 1));
  assign wr_addr   = ckvt_pkg::SlotW'(cmd_r.bucket * ckvt_pkg::ChainDepth) +
                     ckvt_pkg::SlotW'(hit_r ? hit_idx_r : free_idx_r);
  assign wr_val_en = (state_r == B_WRITE) && (cmd_r.func == ckvt_pkg::FUNC_PUT) &&
                     (hit_r || free_seen_r);
  assign wr_key_en = wr_val_en && !hit_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (cmd_valid) state_nxt = B_READ;
      B_READ:  state_nxt = B_CHECK;
      B_CHECK: if (cur_hit || last) state_nxt = B_WRITE; else state_nxt = B_READ;
      B_WRITE: state_nxt = B_OUT;
      B_OUT:   if (res_ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_key_en) valid_r[wr_addr] <= 1'b1;
      if (state_r == B_WRITE && cmd_r.func == ckvt_pkg::FUNC_REMOVE && hit_r) begin
        valid_r[wr_addr] <= 1'b0;
      end
    end
    if (state_r == B_READ) begin
      key_rd_r <= key_mem[rd_addr];
      val_rd_r <= val_mem[rd_addr];
    end
    if (wr_key_en) key_mem[wr_addr] <= cmd_r.key;
    if (wr_val_en) val_mem[wr_addr] <= cmd_r.value;
    if (state_r == B_IDLE && cmd_valid) begin
      cmd_r       <= cmd;
      idx_r       <= '0;
      free_seen_r <= 1'b0;
      hit_r       <= 1'b0;
    end
    if (state_r == B_CHECK) begin
      idx_r <= idx_r + 1'b1;
      if (!cur_valid && !free_seen_r) begin
        free_seen_r <= 1'b1;
        free_idx_r  <= idx_lo;
      end
      if (cur_hit) begin
        hit_r     <= 1'b1;
        hit_idx_r <= idx_lo;
        res_r.read_value <= (cmd_r.func == ckvt_pkg::FUNC_GET) ? val_rd_r : '0;
      end else begin
        res_r.read_value <= '0;
      end
    end
    if (state_r == B_WRITE) begin
      case (cmd_r.func) inside
        ckvt_pkg::FUNC_PUT:    res_r.status <= (hit_r || free_seen_r) ?
                                 ckvt_pkg::ST_OK : ckvt_pkg::ST_FULL;
        ckvt_pkg::FUNC_GET,
        ckvt_pkg::FUNC_REMOVE: res_r.status <= hit_r ? ckvt_pkg::ST_OK : ckvt_pkg::ST_MISS;
        default:               res_r.status <= ckvt_pkg::ST_OK;
      endcase
      if (cmd_r.func == ckvt_pkg::FUNC_NOP) res_r.read_value <= '0;
    end
  end

  assign cmd_ready = (state_r == B_IDLE);
  assign res_valid = (state_r == B_OUT);
  assign res       = res_r;

  `CKV_ASSERT_IMP(a_b_write, clk, rst_n, wr_val_en, cmd_r.func == ckvt_pkg::FUNC_PUT,
    "slot written by a non-put command")
  `CKV_ASSERT_IMP(a_b_full, clk, rst_n, res_valid && res_r.status == ckvt_pkg::ST_FULL,
    res_r.read_value == '0, "full status carries a value")
  `CKV_ASSERT_NXT(a_b_walk, clk, rst_n, state_r == B_CHECK && !cur_hit && !last,
    state_r == B_READ, "chain walk stopped early")
endmodule
`default_nettype wire

// ===== hw/rtl/chained_int_key_value_table_unit.sv =====
// Top level of the chained key/value table; instantiates front, queue, back.
// Depends on ckvt_pkg and the ckvt_* modules.
// The result beat follows the front's 31-step modulo, the hand-off through the queue, and
// then the back's read and check of each chain slot walked, its write and its output state.
// The front takes no new beat until the modulo of the last one is handed off.
// Reset clears all slot valid bits at once and sets bucket_count to 64.
`default_nettype none
module chained_int_key_value_table_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire ckvt_pkg::in_item_t          in_item,
  output logic                             empty,
  input  wire logic                        pop,
  output ckvt_pkg::out_item_t              out_item,
  input  wire logic                        cfg_we,
  input  wire logic [ckvt_pkg::CountW-1:0] cfg_bucket_count
);
  // The bucket count register; zero or above the maximum acts as the maximum.
  logic [ckvt_pkg::CountW-1:0] count_r;
  logic           f_valid, f_ready, b_valid, b_ready, res_valid;
  ckvt_pkg::cmd_t f_cmd, b_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= ckvt_pkg::CountW'(ckvt_pkg::MaxBuckets);
    end else if (cfg_we) begin
      count_r <= cfg_bucket_count;
    end
  end

  // The front takes one beat at a time and computes its bucket.
  ckvt_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .count(count_r), .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  // A short queue lets the front start the next modulo while the back works.
  ckvt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_cmd(b_cmd)
  );

  // The back walks the chain and holds the result until it is popped.
  ckvt_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
    .res_valid(res_valid), .res_ready(pop), .res(out_item)
  );

  assign empty = !res_valid;
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the chained integer key/value table unit.
// Depends on ckvt_pkg and the RTL of chained_int_key_value_table_unit.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import ckvt_pkg::*;

  // The table model and the store of expected responses live in one class.
  // Every accepted command is applied to the model at once, so the model is
  // always in the state the block will reach after its queued commands.
  class table_scoreboard;
    logic [KeyW-1:0] slot_key   [SlotTotal];
    logic [ValW-1:0] slot_value [SlotTotal];
    bit              slot_valid [SlotTotal];
    logic [CountW-1:0] bucket_count;
    out_item_t expected_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function void clear();
      for (int i = 0; i < SlotTotal; i++) slot_valid[i] = 1'b0;
      bucket_count = CountW'(MaxBuckets);
      expected_q.delete();
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_buckets(logic [CountW-1:0] count);
      bucket_count = count;
    endfunction

    // Zero and anything above the table size fall back to the full size.
    function int unsigned live_buckets();
      if (bucket_count == 0 || bucket_count > MaxBuckets) return MaxBuckets;
      return bucket_count;
    endfunction

    function int find_key(int unsigned base, logic [KeyW-1:0] key);
      for (int i = 0; i < ChainDepth; i++)
        if (slot_valid[base + i] && slot_key[base + i] == key) return base + i;
      return -1;
    endfunction

    function void note_command(in_item_t cmd);
      int unsigned base;
      int hit;
      out_item_t resp;
      base = (cmd.key % live_buckets()) * ChainDepth;
      resp.status = ST_OK;
      resp.read_value = '0;
      hit = find_key(base, cmd.key);
      case (func_t'(cmd.func))
        FUNC_PUT: begin
          if (hit >= 0) begin
            slot_value[hit] = cmd.value;
          end else begin
            resp.status = ST_FULL;
            for (int i = 0; i < ChainDepth; i++) begin
              if (!slot_valid[base + i]) begin
                slot_valid[base + i] = 1'b1;
                slot_key[base + i] = cmd.key;
                slot_value[base + i] = cmd.value;
                resp.status = ST_OK;
                break;
              end
            end
          end
        end
        FUNC_GET: begin
          if (hit >= 0) resp.read_value = slot_value[hit];
          else resp.status = ST_MISS;
        end
        FUNC_REMOVE: begin
          if (hit >= 0) slot_valid[hit] = 1'b0;
          else resp.status = ST_MISS;
        end
        default: ;
      endcase
      expected_q.push_back(resp);
    endfunction

    function void check_response(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("response with nothing outstanding: status %0d value %h",
               got.status, got.read_value);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %h, got %h", want.read_value, got.read_value);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [CountW-1:0] cfg_bucket_count = CountW'(MaxBuckets);
  in_item_t in_item = '0;
  out_item_t out_item;
  logic full, empty;

  table_scoreboard sb;
  // While calm is set neither side inserts idle cycles.
  bit calm = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  int unsigned cfg_writes = 0;
  localparam int unsigned WatchdogLimit = 4000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chained_int_key_value_table_unit dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_bucket_count(cfg_bucket_count)
  );

  // Result side: random back-pressure, checking of each popped beat, and a
  // watchdog that counts cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) sb.check_response(out_item);
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired with %0d responses outstanding", sb.outstanding());
        $display("Simulation FAILED");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
    pop <= calm || ($urandom_range(0, 99) >= 15);
  end

  // Sends one command. Push is held high across back-to-back beats and only
  // lowered when an idle cycle is inserted or the block is drained.
  task automatic send_command(input func_t f, input logic [KeyW-1:0] key,
                              input logic [ValW-1:0] value);
    in_item_t cmd;
    cmd.func = f;
    cmd.key = key;
    cmd.value = value;
    while (!calm && $urandom_range(0, 99) < 15) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (full);
    sb.note_command(cmd);
    sent++;
  endtask

  // Drains the block; write_buckets uses it to write a new bucket count while idle.
  task automatic drain();
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_buckets(input logic [CountW-1:0] count);
    drain();
    cfg_we <= 1'b1;
    cfg_bucket_count <= count;
    @(posedge clk);
    sb.set_buckets(count);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  // Most keys land in a few buckets at small chain offsets so that chains
  // fill, overflow and get hits; some keys span the whole 31-bit range.
  task automatic random_commands(input int unsigned n);
    func_t f;
    logic [KeyW-1:0] key;
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      calm = (i >= n / 3) && (i < n / 2);
      pick = $urandom_range(0, 99);
      if (pick < 40) f = FUNC_PUT;
      else if (pick < 72) f = FUNC_GET;
      else if (pick < 95) f = FUNC_REMOVE;
      else f = FUNC_NOP;
      pick = $urandom_range(0, 99);
      if (pick < 75)
        key = KeyW'($urandom_range(0, 5) + sb.live_buckets() * $urandom_range(0, 7));
      else if (pick < 90) key = KeyW'($urandom_range(0, 300));
      else key = KeyW'($urandom);
      send_command(f, key, $urandom);
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [CountW-1:0] plan [7] = '{7'd1, 7'd3, 7'd0, 7'd127, 7'd2, 7'd37, 7'd64};
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: key extremes, overwrite, a full chain in bucket zero,
    // remove hit and miss, reuse of a freed slot and the unused code.
    send_command(FUNC_PUT, '0, '0);
    send_command(FUNC_GET, '0, '1);
    send_command(FUNC_PUT, '1, '1);
    send_command(FUNC_GET, '1, '0);
    send_command(FUNC_PUT, 31'd64, 32'h1234_5678);
    send_command(FUNC_PUT, 31'd128, 32'hA5A5_A5A5);
    send_command(FUNC_PUT, 31'd192, 32'h5A5A_5A5A);
    send_command(FUNC_PUT, 31'd256, 32'hDEAD_BEEF);
    send_command(FUNC_PUT, '0, 32'd5);
    send_command(FUNC_GET, '0, '0);
    send_command(FUNC_REMOVE, 31'd64, '0);
    send_command(FUNC_REMOVE, 31'd64, '0);
    send_command(FUNC_GET, 31'd64, '0);
    send_command(FUNC_PUT, 31'd256, 32'hCAFE_F00D);
    send_command(FUNC_GET, 31'd256, '0);
    send_command(FUNC_NOP, 31'd256, '1);
    send_command(FUNC_GET, 31'd12345, '0);
    send_command(FUNC_REMOVE, '1, '0);
    send_command(FUNC_GET, '1, '0);

    random_commands(200);
    foreach (plan[i]) begin
      write_buckets(plan[i]);
      // Old entries stay put under the new divisor and may now be lost.
      send_command(FUNC_GET, 31'd256, '0);
      random_commands(200);
    end

    drain();
    $display("Sent %0d commands over %0d bucket-count settings; checked %0d responses.",
             sent, cfg_writes + 1, sb.checked);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
